FILE: sv/rdq_pkg.sv
`default_nettype none

package rdq_pkg;

  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned DIV_STEPS  = 16;

  localparam logic [15:0] MIN_RANGE_RST  = 16'd200;
  localparam logic [31:0] RCS_NUM_Q8     = 32'd51200000;
  localparam logic [15:0] RANGE_FLOOR    = 16'd1000;
  localparam logic [12:0] RCS_MIN_Q8     = 13'd128;
  localparam logic [12:0] RCS_MAX_Q8     = 13'd7680;
  localparam logic [15:0] ONE_Q15        = 16'd32768;
  localparam logic [15:0] VEL_MIN_Q15    = 16'd6553;
  localparam logic [15:0] CONF_MIN_Q15   = 16'd3277;
  localparam logic [15:0] SPEED_FULL_MMS = 16'd50000;
  localparam logic [31:0] SPEED_SLOW_SQ  = 32'd10000;
  // The speed factor is floor(d * 32768 / 50000) with d = 50000 - speed, which equals
  // (d * SPEED_RECIP) >> 29 for every d up to 50000.
  localparam logic [28:0] SPEED_RECIP    = 29'd351843721;
  // floor(y / 5) == (y * 52429) >> 18 for every y below 2^18.
  localparam logic [15:0] DIV5_MUL       = 16'd52429;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic        [31:0] frame;
  } pay_t;

  typedef struct packed {
    logic [31:0] n;
    logic [15:0] root;
    logic [16:0] rem;
  } sqrt_st_t;

  typedef struct packed {
    logic [15:0] dd;
    logic [15:0] dv;
    logic [15:0] rem;
    logic [15:0] q;
  } div_st_t;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic [15:0] r;
    r = v[15] ? (~v + 16'd1) : v;
    return r;
  endfunction

  // One result bit of the digit-by-digit square root.
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
    sqrt_st_t    o;
    logic [18:0] rem_n;
    logic [18:0] trial;
    rem_n = {s.rem[16:0], s.n[31:30]};
    trial = {1'b0, s.root, 2'b01};
    o.n   = {s.n[29:0], 2'b00};
    if (rem_n >= trial) begin
      o.rem  = 17'(rem_n - trial);
      o.root = {s.root[14:0], 1'b1};
    end else begin
      o.rem  = rem_n[16:0];
      o.root = {s.root[14:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit of restoring division; the remainder stays below the divisor.
  function automatic div_st_t div_step(input div_st_t s);
    div_st_t     o;
    logic [16:0] rem_n;
    rem_n = {s.rem, s.dd[15]};
    o.dd  = {s.dd[14:0], 1'b0};
    o.dv  = s.dv;
    if (rem_n >= {1'b0, s.dv}) begin
      o.rem = 16'(rem_n - {1'b0, s.dv});
      o.q   = {s.q[14:0], 1'b1};
    end else begin
      o.rem = rem_n[15:0];
      o.q   = {s.q[14:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: sv/radar_detection_qualifier_top.sv
`default_nettype none
// Channel  | Direction | Handshake           | Payload
// in_      | input     | in_valid / in_stall | position, velocity, frame time
// out_     | output    | out_valid/out_stall | copies, range, reflectivity, confidence
// cfg_     | input     | cfg_wr_en           | minimum range in mm
//
// One beat enters per cycle while the output beat is not stalled; the path runs through the
// 16-step square root pipeline followed by the 16-step divider pipeline.
// Reset is synchronous and active low; it clears the valid bits and sets the
// minimum range to 200 mm.
// The whole pipeline advances together; it holds while the output beat is stalled.

module radar_detection_qualifier_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic        [15:0] cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_pos_x_mm,
  input  wire logic signed [15:0] in_pos_y_mm,
  input  wire logic signed [15:0] in_pos_z_mm,
  input  wire logic signed [15:0] in_vel_x_mms,
  input  wire logic signed [15:0] in_vel_y_mms,
  input  wire logic signed [15:0] in_vel_z_mms,
  input  wire logic        [31:0] in_frame_time,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [15:0] out_pos_x_mm,
  output logic signed      [15:0] out_pos_y_mm,
  output logic signed      [15:0] out_pos_z_mm,
  output logic signed      [15:0] out_vel_x_mms,
  output logic signed      [15:0] out_vel_y_mms,
  output logic signed      [15:0] out_vel_z_mms,
  output logic             [15:0] out_range_mm,
  output logic             [12:0] out_reflectivity_q8,
  output logic             [15:0] out_confidence_q15,
  output logic             [31:0] out_frame_time
);
  import rdq_pkg::*;

  logic        adv;
  logic [15:0] min_range_r;
  logic [31:0] mr_sq_r;

  // Stage 1: squares.
  logic        v1_r;
  pay_t        pay1_r;
  logic [31:0] sq_r [6];

  // Square root stages; index 0 holds the sums.
  logic     sv_r    [SQRT_STEPS+1];
  pay_t     spay_r  [SQRT_STEPS+1];
  logic     sslow_r [SQRT_STEPS+1];
  sqrt_st_t ps_r    [SQRT_STEPS+1];
  sqrt_st_t vs_r    [SQRT_STEPS+1];

  // Stage between root and division.
  logic        v3_r;
  pay_t        pay3_r;
  logic        slow3_r;
  logic [15:0] range3_r;
  logic [15:0] rdiv3_r;
  logic [15:0] d3_r;

  // Divider stages; index 0 holds the initial remainders.
  logic        dv_r     [DIV_STEPS+1];
  pay_t        dpay_r   [DIV_STEPS+1];
  logic        dslow_r  [DIV_STEPS+1];
  logic [15:0] drange_r [DIV_STEPS+1];
  div_st_t     pd_r     [DIV_STEPS+1];
  logic [15:0] vq_r     [DIV_STEPS+1];

  // Confidence stages.
  logic        c1v_r, c2v_r, c3v_r;
  pay_t        c1pay_r, c2pay_r, c3pay_r;
  logic [15:0] c1range_r, c2range_r, c3range_r;
  logic [12:0] c1rcs_r, c2rcs_r, c3rcs_r;
  logic [15:0] c1vfac_r;
  logic [32:0] c1prod_r;
  logic [30:0] c2prod_r;
  logic [15:0] c3conf_r;

  logic [31:0] psum, vsum;
  logic [15:0] s3_range, s3_speed, s3_d;
  logic [44:0] vprod;
  logic [15:0] c1_qp, c1_qv;
  logic [12:0] c1_rcs;
  logic [15:0] c1_vfac;
  logic [15:0] c2_rfac;
  logic [15:0] c3_conf;

  assign adv      = !c3v_r || !out_stall;
  assign in_stall = !adv;

  assign psum = sq_r[0] + sq_r[1] + sq_r[2];
  assign vsum = sq_r[3] + sq_r[4] + sq_r[5];

  always_comb begin
    s3_range = ps_r[SQRT_STEPS].root;
    s3_speed = vs_r[SQRT_STEPS].root;
    s3_d     = (s3_speed >= SPEED_FULL_MMS) ? 16'd0 : 16'(SPEED_FULL_MMS - s3_speed);
  end

  // The speed factor comes from one reciprocal multiplication.
  assign vprod = {29'd0, d3_r} * {16'd0, SPEED_RECIP};

  always_comb begin
    c1_qp = pd_r[DIV_STEPS].q;
    c1_qv = vq_r[DIV_STEPS];
    if (c1_qp < 16'(RCS_MIN_Q8)) begin
      c1_rcs = RCS_MIN_Q8;
    end else if (c1_qp > 16'(RCS_MAX_Q8)) begin
      c1_rcs = RCS_MAX_Q8;
    end else begin
      c1_rcs = c1_qp[12:0];
    end
    if (dslow_r[DIV_STEPS]) begin
      c1_vfac = ONE_Q15;
    end else if (c1_qv < VEL_MIN_Q15) begin
      c1_vfac = VEL_MIN_Q15;
    end else begin
      c1_vfac = c1_qv;
    end
  end

  assign c2_rfac = {1'b0, c1prod_r[32:18]};

  always_comb begin
    if (c2prod_r[30:15] < CONF_MIN_Q15) begin
      c3_conf = CONF_MIN_Q15;
    end else if (c2prod_r[30:15] > ONE_Q15) begin
      c3_conf = ONE_Q15;
    end else begin
      c3_conf = c2prod_r[30:15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= MIN_RANGE_RST;
    end else if (cfg_wr_en) begin
      min_range_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    mr_sq_r <= {16'd0, min_range_r} * {16'd0, min_range_r};
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v3_r  <= 1'b0;
      c1v_r <= 1'b0;
      c2v_r <= 1'b0;
      c3v_r <= 1'b0;
      for (int i = 0; i <= SQRT_STEPS; i++) sv_r[i] <= 1'b0;
      for (int i = 0; i <= DIV_STEPS; i++) dv_r[i] <= 1'b0;
    end else if (adv) begin
      v1_r  <= in_valid;
      // A detection inside the minimum range is dropped here.
      sv_r[0] <= v1_r && (psum >= mr_sq_r);
      for (int i = 1; i <= SQRT_STEPS; i++) sv_r[i] <= sv_r[i-1];
      v3_r  <= sv_r[SQRT_STEPS];
      dv_r[0] <= v3_r;
      for (int i = 1; i <= DIV_STEPS; i++) dv_r[i] <= dv_r[i-1];
      c1v_r <= dv_r[DIV_STEPS];
      c2v_r <= c1v_r;
      c3v_r <= c2v_r;
    end
  end

  // Data path.
  always_ff @(posedge clk) begin
    if (adv) begin
      pay1_r <= '{in_pos_x_mm, in_pos_y_mm, in_pos_z_mm,
                  in_vel_x_mms, in_vel_y_mms, in_vel_z_mms, in_frame_time};
      sq_r[0] <= {16'd0, abs16(in_pos_x_mm)} * {16'd0, abs16(in_pos_x_mm)};
      sq_r[1] <= {16'd0, abs16(in_pos_y_mm)} * {16'd0, abs16(in_pos_y_mm)};
      sq_r[2] <= {16'd0, abs16(in_pos_z_mm)} * {16'd0, abs16(in_pos_z_mm)};
      sq_r[3] <= {16'd0, abs16(in_vel_x_mms)} * {16'd0, abs16(in_vel_x_mms)};
      sq_r[4] <= {16'd0, abs16(in_vel_y_mms)} * {16'd0, abs16(in_vel_y_mms)};
      sq_r[5] <= {16'd0, abs16(in_vel_z_mms)} * {16'd0, abs16(in_vel_z_mms)};

      spay_r[0]  <= pay1_r;
      sslow_r[0] <= vsum <= SPEED_SLOW_SQ;
      ps_r[0]    <= '{psum, 16'd0, 17'd0};
      vs_r[0]    <= '{vsum, 16'd0, 17'd0};
      for (int i = 1; i <= SQRT_STEPS; i++) begin
        spay_r[i]  <= spay_r[i-1];
        sslow_r[i] <= sslow_r[i-1];
        ps_r[i]    <= sqrt_step(ps_r[i-1]);
        vs_r[i]    <= sqrt_step(vs_r[i-1]);
      end

      pay3_r   <= spay_r[SQRT_STEPS];
      slow3_r  <= sslow_r[SQRT_STEPS];
      range3_r <= s3_range;
      rdiv3_r  <= (s3_range < RANGE_FLOOR) ? RANGE_FLOOR : s3_range;
      d3_r     <= s3_d;

      dpay_r[0]   <= pay3_r;
      dslow_r[0]  <= slow3_r;
      drange_r[0] <= range3_r;
      pd_r[0]     <= '{RCS_NUM_Q8[15:0], rdiv3_r, RCS_NUM_Q8[31:16], 16'd0};
      vq_r[0]     <= vprod[44:29];
      for (int i = 1; i <= DIV_STEPS; i++) begin
        dpay_r[i]   <= dpay_r[i-1];
        dslow_r[i]  <= dslow_r[i-1];
        drange_r[i] <= drange_r[i-1];
        pd_r[i]     <= div_step(pd_r[i-1]);
        vq_r[i]     <= vq_r[i-1];
      end

      c1pay_r   <= dpay_r[DIV_STEPS];
      c1range_r <= drange_r[DIV_STEPS];
      c1rcs_r   <= c1_rcs;
      c1vfac_r  <= c1_vfac;
      c1prod_r  <= {16'd0, c1_rcs, 4'd0} * {17'd0, DIV5_MUL};

      c2pay_r   <= c1pay_r;
      c2range_r <= c1range_r;
      c2rcs_r   <= c1rcs_r;
      c2prod_r  <= {16'd0, c2_rfac[14:0]} * {15'd0, c1vfac_r};

      c3pay_r   <= c2pay_r;
      c3range_r <= c2range_r;
      c3rcs_r   <= c2rcs_r;
      c3conf_r  <= c3_conf;
    end
  end

  assign out_valid           = c3v_r;
  assign out_pos_x_mm        = c3pay_r.pos_x;
  assign out_pos_y_mm        = c3pay_r.pos_y;
  assign out_pos_z_mm        = c3pay_r.pos_z;
  assign out_vel_x_mms       = c3pay_r.vel_x;
  assign out_vel_y_mms       = c3pay_r.vel_y;
  assign out_vel_z_mms       = c3pay_r.vel_z;
  assign out_frame_time      = c3pay_r.frame;
  assign out_range_mm        = c3range_r;
  assign out_reflectivity_q8 = c3rcs_r;
  assign out_confidence_q15  = c3conf_r;

endmodule

`default_nettype wire

FILE: sv/rdq_checker.sv
`default_nettype none

module rdq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_range_mm,
  input wire logic [12:0] out_reflectivity_q8,
  input wire logic [15:0] out_confidence_q15
);
  import rdq_pkg::*;

  // The pipeline holds exactly when a finished beat waits at the output.
  a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not match output back-pressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_range_mm)
      && $stable(out_confidence_q15))
    else $error("stalled output beat changed");

  a_rcs_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reflectivity_q8 >= RCS_MIN_Q8) && (out_reflectivity_q8 <= RCS_MAX_Q8))
    else $error("reflectivity outside its clamp");

  a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_confidence_q15 >= CONF_MIN_Q15) && (out_confidence_q15 <= ONE_Q15))
    else $error("confidence outside its clamp");

endmodule

bind radar_detection_qualifier_top rdq_checker u_rdq_checker (.*);

`default_nettype wire
